// ===== rtl/core/cdq_pkg.sv =====
`timescale 1ns / 1ps
// shared types and codes for the circular double-ended queue
package cdq_pkg;

    localparam int WORD_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [STAT_W-1:0] status_t;
    typedef logic signed [WORD_W-1:0] word_t;

    localparam cmd_t CMD_PUSH_FRONT = 3'd0;
    localparam cmd_t CMD_PUSH_REAR  = 3'd1;
    localparam cmd_t CMD_POP_FRONT  = 3'd2;
    localparam cmd_t CMD_POP_REAR   = 3'd3;
    localparam cmd_t CMD_PEEK_FRONT = 3'd4;
    localparam cmd_t CMD_PEEK_REAR  = 3'd5;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

endpackage

// ===== rtl/core/circular_double_ended_queue.sv =====
`timescale 1ns / 1ps
// circular double-ended queue: top level with index control and result register
//
//   channel | signals                                     | dir
//   --------+---------------------------------------------+-----
//   request | in_valid, in_ready, cmd, value              | in
//   result  | out_valid, out_ready, data_out, status,     | out
//           | occupancy, is_empty, is_full                |
//
// a request is taken into the single pending stage while the word store reads, and
// its result loads the output register once that register is free; so a new request
// is not taken until the result of the last one has loaded the output register.
// reset (rst_n low) empties the queue; stored words are not cleared.
// a stalled result (out_ready low) holds the pending stage and blocks requests.
module circular_double_ended_queue
    import cdq_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  cmd_t                           cmd,
    input  word_t                          value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output word_t                          data_out,
    output status_t                        status,
    output logic [$clog2(DEPTH+1)-1:0]     occupancy,
    output logic                           is_empty,
    output logic                           is_full
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [AW-1:0] front_reg, front_next;
    logic [AW-1:0] rear_reg, rear_next;
    logic [CW-1:0] count_reg, count_next;

    // pending stage between request and result register
    logic          busy_reg;
    logic          pend_rd_reg;
    status_t       pend_status_reg;
    logic [CW-1:0] pend_count_reg;

    logic          out_valid_reg;
    word_t         data_out_reg;
    status_t       status_reg;
    logic [CW-1:0] occupancy_reg;

    logic          in_fire;
    logic          out_load;
    logic          q_empty;
    logic          q_full;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    status_t       st_next;
    word_t         rd_data;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i);
        return (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    assign in_ready = !busy_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_load = busy_reg && (!out_valid_reg || out_ready);
    assign q_empty  = (count_reg == '0);
    assign q_full   = (count_reg == FULL_CNT);

    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        rd_en      = 1'b0;
        rd_addr    = front_reg;
        st_next    = ST_OK;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_REAR:
            begin
                if (q_full)
                begin
                    st_next = ST_FULL;
                end
                else if (q_empty)
                begin
                    front_next = '0;
                    rear_next  = '0;
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    count_next = CW'(1);
                end
                else if (cmd == CMD_PUSH_FRONT)
                begin
                    front_next = wrap_dec(front_reg);
                    wr_en      = 1'b1;
                    wr_addr    = front_next;
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    rear_next  = wrap_inc(rear_reg);
                    wr_en      = 1'b1;
                    wr_addr    = rear_next;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_POP_FRONT, CMD_POP_REAR:
            begin
                if (q_empty)
                begin
                    st_next = ST_EMPTY;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = (cmd == CMD_POP_FRONT) ? front_reg : rear_reg;
                    if (count_reg == CW'(1))
                    begin
                        front_next = '0;
                        rear_next  = '0;
                    end
                    else if (cmd == CMD_POP_FRONT)
                    begin
                        front_next = wrap_inc(front_reg);
                    end
                    else
                    begin
                        rear_next = wrap_dec(rear_reg);
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_PEEK_FRONT, CMD_PEEK_REAR:
            begin
                if (q_empty)
                begin
                    st_next = ST_EMPTY;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = (cmd == CMD_PEEK_FRONT) ? front_reg : rear_reg;
                end
            end
            default:
            begin
                st_next = ST_OK;
            end
        endcase
    end

    // store accesses happen only on the accept cycle, so a write always lands
    // before any later read of the same slot
    cdq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en && in_fire),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (rd_en && in_fire),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            rear_reg      <= '0;
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                front_reg <= front_next;
                rear_reg  <= rear_next;
                count_reg <= count_next;
                busy_reg  <= 1'b1;
            end
            else if (out_load)
            begin
                busy_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pend_rd_reg     <= rd_en;
            pend_status_reg <= st_next;
            pend_count_reg  <= count_next;
        end
        if (out_load)
        begin
            data_out_reg  <= pend_rd_reg ? rd_data : '0;
            status_reg    <= pend_status_reg;
            occupancy_reg <= pend_count_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign status    = status_reg;
    assign occupancy = occupancy_reg;
    assign is_empty  = (occupancy_reg == '0);
    assign is_full   = (occupancy_reg == FULL_CNT);

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("stored count above depth");

    a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (front_reg == '0) && (rear_reg == '0))
        else $error("indices not home on empty queue");

    a_single_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CW'(1)) |-> (front_reg == rear_reg))
        else $error("front and rear differ with one word stored");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (data_out == '0))
        else $error("refused request returned data");

    a_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> busy_reg && !in_ready)
        else $error("request not held in pending stage");

endmodule

// ===== rtl/core/cdq_ram.sv =====
`timescale 1ns / 1ps
// word store of the queue: one write port, one registered read port
module cdq_ram
    import cdq_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  word_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output word_t         rd_data
);

    word_t mem [DEPTH];
    word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
